// ===== rtl/leaf_spine_next_hop_select_macros.svh =====
// Assertion helpers for the next-hop selector.
`ifndef LEAF_SPINE_NEXT_HOP_SELECT_MACROS_SVH
`define LEAF_SPINE_NEXT_HOP_SELECT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define LSNHS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsnhs: same-cycle check failed");

// Next-cycle implication.
`define LSNHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsnhs: next-cycle check failed");

`else

`define LSNHS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define LSNHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/lsnhs_pkg.sv =====
package lsnhs_pkg;

  localparam int MODE_W      = 2;
  localparam int HOST_W      = 8;
  localparam int FLOW_W      = 32;
  localparam int BAL_W       = 2;
  localparam int PORT_W      = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  localparam int HOSTS_RACK_DEF = 16;
  localparam int UPLINKS_DEF    = 4;
  localparam int HOST_COUNT_DEF = 256;

  // link kinds
  localparam logic [MODE_W-1:0] MODE_HOST_IN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPLINK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AGG     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CORE    = 2'd3;

  // uplink balancing
  localparam logic [BAL_W-1:0] BAL_SPRAY = 2'd0;
  localparam logic [BAL_W-1:0] BAL_ECMP  = 2'd1;

  // request as held in the decision stage; sum is src + dst + flow, wrapped
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HOST_W-1:0] src;
    logic [HOST_W-1:0] dst;
    logic [FLOW_W-1:0] sum;
  } item_t;

endpackage

// ===== rtl/lsnhs_spray_mem.sv =====
module lsnhs_spray_mem #(
  parameter int HOST_COUNT = lsnhs_pkg::HOST_COUNT_DEF,
  parameter int CW         = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [lsnhs_pkg::HOST_W-1:0] rd_src,
  input  logic                        wr_en,
  input  logic [lsnhs_pkg::HOST_W-1:0] wr_src,
  input  logic [CW-1:0]               wr_cnt,
  output logic [CW-1:0]               cnt
);

  // only the first 256 counters can ever be addressed by an 8-bit host id
  localparam int DEPTH = (HOST_COUNT < 256) ? HOST_COUNT : 256;
  localparam int AW    = $clog2(DEPTH);

  logic [AW-1:0] idx_tab [256];
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_idx;

  logic [CW-1:0]    spray_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [CW-1:0]    rd_data_r;
  logic             rd_vld_r;
  logic             fwd_r;
  logic [CW-1:0]    fwd_data_r;

  for (genvar g = 0; g < 256; g++) begin : g_idx
    localparam int IDX = g % HOST_COUNT;
    assign idx_tab[g] = AW'(IDX);
  end

  assign rd_idx = idx_tab[rd_src];
  assign wr_idx = idx_tab[wr_src];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      spray_r[wr_idx] <= wr_cnt;
    end
    if (rd_en) begin
      rd_data_r  <= spray_r[rd_idx];
      fwd_data_r <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
        // write-back landing on the same edge as the read: take it directly
        fwd_r    <= wr_en && (wr_idx == rd_idx);
      end
    end
  end

  assign cnt = fwd_r ? fwd_data_r : (rd_vld_r ? rd_data_r : '0);

endmodule

// ===== rtl/lsnhs_hash.sv =====
module lsnhs_hash #(
  parameter int  UPLINKS = lsnhs_pkg::UPLINKS_DEF,
  localparam int CW      = (UPLINKS > 1) ? $clog2(UPLINKS) : 1
) (
  input  logic [lsnhs_pkg::FLOW_W-1:0] sum,
  output logic [CW-1:0]                pick
);

  // weight of each byte of the sum, modulo UPLINKS
  localparam int W0 = 1 % UPLINKS;
  localparam int W1 = 256 % UPLINKS;
  localparam int W2 = 65536 % UPLINKS;
  localparam int W3 = 16777216 % UPLINKS;
  localparam int H1 = 256 % UPLINKS;
  localparam int H2 = 512 % UPLINKS;
  localparam int H3 = 768 % UPLINKS;

  logic [CW-1:0] mod_tab [256];
  logic [9:0]    part;
  logic [CW:0]   hi_res;
  logic [CW:0]   red;

  for (genvar g = 0; g < 256; g++) begin : g_mod
    localparam int RES = g % UPLINKS;
    assign mod_tab[g] = CW'(RES);
  end

  always_comb begin
    // partial sum stays below 4 * 15 * 15, so it fits ten bits
    part = 10'(mod_tab[sum[7:0]])   * 10'(W0)
         + 10'(mod_tab[sum[15:8]])  * 10'(W1)
         + 10'(mod_tab[sum[23:16]]) * 10'(W2)
         + 10'(mod_tab[sum[31:24]]) * 10'(W3);
    case (part[9:8])
      2'd1:    hi_res = (CW+1)'(H1);
      2'd2:    hi_res = (CW+1)'(H2);
      2'd3:    hi_res = (CW+1)'(H3);
      default: hi_res = '0;
    endcase
    red  = (CW+1)'(mod_tab[part[7:0]]) + hi_res;
    pick = (red >= (CW+1)'(UPLINKS)) ? CW'(red - (CW+1)'(UPLINKS)) : CW'(red);
  end

endmodule

// ===== rtl/lsnhs_route.sv =====
module lsnhs_route #(
  parameter int  HOSTS_RACK = lsnhs_pkg::HOSTS_RACK_DEF,
  parameter int  UPLINKS    = lsnhs_pkg::UPLINKS_DEF,
  localparam int CW         = (UPLINKS > 1) ? $clog2(UPLINKS) : 1
) (
  input  lsnhs_pkg::item_t             item,
  input  logic [lsnhs_pkg::BAL_W-1:0]  bal,
  input  logic [CW-1:0]                cnt,
  input  logic [CW-1:0]                hash_pick,
  output logic                         arrived,
  output logic [lsnhs_pkg::PORT_W-1:0] port,
  output logic                         upd_en,
  output logic [CW-1:0]                upd_cnt
);

  logic [7:0]    rack_tab [256];
  logic [7:0]    port_tab [256];
  logic [7:0]    src_rack;
  logic [7:0]    dst_rack;
  logic [7:0]    dst_port;
  logic [CW-1:0] pick;
  logic [7:0]    up_port;

  for (genvar g = 0; g < 256; g++) begin : g_rack
    localparam int RACK = g / HOSTS_RACK;
    localparam int RPRT = g % HOSTS_RACK;
    assign rack_tab[g] = 8'(RACK);
    assign port_tab[g] = 8'(RPRT);
  end

  always_comb begin
    src_rack = rack_tab[item.src];
    dst_rack = rack_tab[item.dst];
    dst_port = port_tab[item.dst];

    case (bal)
      lsnhs_pkg::BAL_SPRAY: pick = cnt;
      lsnhs_pkg::BAL_ECMP:  pick = hash_pick;
      default:              pick = '0;
    endcase
    up_port = 8'(HOSTS_RACK) + 8'(pick);

    // counter wraps at UPLINKS
    upd_cnt = (cnt == CW'(UPLINKS - 1)) ? '0 : cnt + CW'(1);

    arrived = 1'b0;
    port    = '0;
    upd_en  = 1'b0;
    case (item.mode)
      lsnhs_pkg::MODE_HOST_IN: arrived = 1'b1;
      lsnhs_pkg::MODE_UPLINK: begin
        if (src_rack == dst_rack) begin
          port = dst_port[lsnhs_pkg::PORT_W-1:0];
        end else begin
          port   = up_port[lsnhs_pkg::PORT_W-1:0];
          upd_en = (bal == lsnhs_pkg::BAL_SPRAY);
        end
      end
      lsnhs_pkg::MODE_AGG:  port = dst_rack[lsnhs_pkg::PORT_W-1:0];
      lsnhs_pkg::MODE_CORE: port = dst_port[lsnhs_pkg::PORT_W-1:0];
      default:              port = dst_port[lsnhs_pkg::PORT_W-1:0];
    endcase
  end

endmodule

// ===== rtl/leaf_spine_next_hop_select.sv =====
// Next-hop selector for a two-tier leaf-spine fabric. Takes one request per
// cycle when not held by backpressure and returns one result per request:
// the request is registered (with src + dst + flow summed on the way in), the
// port is decided in one pass, and the result sits in an output register that
// holds under backpressure while one more request can still enter an empty
// decision stage. The spray counter memory keeps pace: its read is issued as
// a request is taken and the advanced count is written back as that request
// leaves the decision stage, with a bypass for back-to-back requests from the
// same source host. The counters carry per-entry valid bits cleared by reset,
// so no clearing pass is needed and the block is ready straight out of reset.
`include "leaf_spine_next_hop_select_macros.svh"

module leaf_spine_next_hop_select #(
  parameter int  HOSTS_RACK = lsnhs_pkg::HOSTS_RACK_DEF,
  parameter int  UPLINKS    = lsnhs_pkg::UPLINKS_DEF,
  parameter int  HOST_COUNT = lsnhs_pkg::HOST_COUNT_DEF,
  localparam int CW         = (UPLINKS > 1) ? $clog2(UPLINKS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lsnhs_pkg::BAL_W-1:0]       cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lsnhs_pkg::IN_TDATA_W-1:0]  in_tdata,   // src_host, dst_host, flow_id
  input  logic [lsnhs_pkg::MODE_W-1:0]      in_tuser,   // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lsnhs_pkg::OUT_TDATA_W-1:0] out_tdata,  // out_port, zero pad
  output logic                              out_tuser   // arrived
);

  logic [lsnhs_pkg::BAL_W-1:0]  bal_r;
  lsnhs_pkg::item_t             s1_r;
  lsnhs_pkg::item_t             s1_nxt;
  logic                         s1_v_r;
  logic                         out_v_r;
  logic                         out_arr_r;
  logic [lsnhs_pkg::PORT_W-1:0] out_port_r;

  logic                         adv;
  logic                         acc;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                hash_pick;
  logic                         arrived;
  logic [lsnhs_pkg::PORT_W-1:0] port;
  logic                         upd_en;
  logic [CW-1:0]                upd_cnt;
  logic                         wr_en;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv;
  assign acc       = in_tvalid && in_tready;
  assign wr_en     = adv && s1_v_r && upd_en;

  always_comb begin
    s1_nxt.mode = in_tuser;
    s1_nxt.src  = in_tdata[7:0];
    s1_nxt.dst  = in_tdata[15:8];
    s1_nxt.sum  = 32'(in_tdata[7:0]) + 32'(in_tdata[15:8]) + in_tdata[47:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bal_r   <= lsnhs_pkg::BAL_SPRAY;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bal_r <= cfg_wr_data;
      end
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
    if (adv && s1_v_r) begin
      out_arr_r  <= arrived;
      out_port_r <= port;
    end
  end

  lsnhs_spray_mem #(
    .HOST_COUNT (HOST_COUNT),
    .CW         (CW)
  ) u_spray (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (acc),
    .rd_src (s1_nxt.src),
    .wr_en  (wr_en),
    .wr_src (s1_r.src),
    .wr_cnt (upd_cnt),
    .cnt    (cnt)
  );

  lsnhs_hash #(
    .UPLINKS (UPLINKS)
  ) u_hash (
    .sum  (s1_r.sum),
    .pick (hash_pick)
  );

  lsnhs_route #(
    .HOSTS_RACK (HOSTS_RACK),
    .UPLINKS    (UPLINKS)
  ) u_route (
    .item      (s1_r),
    .bal       (bal_r),
    .cnt       (cnt),
    .hash_pick (hash_pick),
    .arrived   (arrived),
    .port      (port),
    .upd_en    (upd_en),
    .upd_cnt   (upd_cnt)
  );

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_arr_r;
  assign out_tdata  = {{(lsnhs_pkg::OUT_TDATA_W - lsnhs_pkg::PORT_W){1'b0}}, out_port_r};

  `LSNHS_ASSERT_SAME(a_stall_blocks_in, clk, rst_n, s1_v_r && out_v_r && !out_tready, !in_tready)
  `LSNHS_ASSERT_SAME(a_upd_only_spray, clk, rst_n, s1_v_r && upd_en,
                     (bal_r == lsnhs_pkg::BAL_SPRAY) && (s1_r.mode == lsnhs_pkg::MODE_UPLINK))
  `LSNHS_ASSERT_SAME(a_arrived_port0, clk, rst_n, out_v_r && out_tuser, out_tdata == '0)
  `LSNHS_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_tvalid && in_tready, s1_v_r)

endmodule

// ===== tb/sv/tb_leaf_spine_next_hop_select.sv =====
`timescale 1ns / 100ps

module tb_leaf_spine_next_hop_select;

  localparam int MODE_W      = lsnhs_pkg::MODE_W;
  localparam int HOST_W      = lsnhs_pkg::HOST_W;
  localparam int FLOW_W      = lsnhs_pkg::FLOW_W;
  localparam int BAL_W       = lsnhs_pkg::BAL_W;
  localparam int PORT_W      = lsnhs_pkg::PORT_W;
  localparam int IN_TDATA_W  = lsnhs_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = lsnhs_pkg::OUT_TDATA_W;
  localparam int HOSTS_RACK  = lsnhs_pkg::HOSTS_RACK_DEF;
  localparam int UPLINKS     = lsnhs_pkg::UPLINKS_DEF;
  localparam int HOST_COUNT  = lsnhs_pkg::HOST_COUNT_DEF;

  localparam logic [BAL_W-1:0] BAL_FIXED_LO = 2'd2;
  localparam logic [BAL_W-1:0] BAL_FIXED_HI = 2'd3;
  localparam int PHASE_ITEMS = 190;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HOST_W-1:0] src;
    logic [HOST_W-1:0] dst;
    logic [FLOW_W-1:0] flow;
  } pkt_t;

  typedef struct packed {
    logic              arrived;
    logic [PORT_W-1:0] port;
  } hop_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [BAL_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // src_host, dst_host, flow_id
  logic [MODE_W-1:0]      in_tuser = '0;   // mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // out_port, zero pad
  logic                   out_tuser;       // arrived

  pkt_t       pkt_q[$];
  hop_t       hop_q[$];
  logic [1:0] spray_cnt[HOST_COUNT];
  logic [BAL_W-1:0] bal_mode = lsnhs_pkg::BAL_SPRAY;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         n_errors = 0;
  int         n_sent = 0;
  int         n_checked = 0;
  int         n_queued = 0;

  always #2 clk = ~clk;

  leaf_spine_next_hop_select u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // next-hop decision; advances the spray counter of the source host on cross-rack uplink spraying
  function automatic hop_t predict_hop(logic [MODE_W-1:0] mode, logic [HOST_W-1:0] src,
                                       logic [HOST_W-1:0] dst, logic [FLOW_W-1:0] flow);
    hop_t        h;
    logic [31:0] sum;
    logic [1:0]  pick;
    h = '0;
    case (mode)
      lsnhs_pkg::MODE_HOST_IN: begin
        h.arrived = 1'b1;
      end
      lsnhs_pkg::MODE_UPLINK: begin
        if (src / HOSTS_RACK == dst / HOSTS_RACK) begin
          h.port = PORT_W'(dst % HOSTS_RACK);
        end else begin
          pick = '0;
          if (bal_mode == lsnhs_pkg::BAL_SPRAY) begin
            pick = 2'(spray_cnt[src % HOST_COUNT] % UPLINKS);
            spray_cnt[src % HOST_COUNT] = 2'((pick + 1) % UPLINKS);
          end else if (bal_mode == lsnhs_pkg::BAL_ECMP) begin
            sum  = 32'(src) + 32'(dst) + flow;
            pick = 2'(sum % UPLINKS);
          end
          h.port = PORT_W'(HOSTS_RACK + pick);
        end
      end
      lsnhs_pkg::MODE_AGG: begin
        h.port = PORT_W'(dst / HOSTS_RACK);
      end
      default: begin
        h.port = PORT_W'(dst % HOSTS_RACK);
      end
    endcase
    return h;
  endfunction

  // biased towards cross-rack uplink traffic from a few busy hosts
  function automatic pkt_t rand_pkt();
    pkt_t p;
    logic [HOST_W-1:0] busy[4] = '{8'h00, 8'h37, 8'hA5, 8'hFF};
    p.mode = ($urandom_range(99) < 55) ? lsnhs_pkg::MODE_UPLINK : MODE_W'($urandom_range(3));
    p.src  = ($urandom_range(99) < 40) ? busy[$urandom_range(3)] : HOST_W'($urandom);
    p.dst  = ($urandom_range(99) < 30) ? {p.src[7:4], 4'($urandom)} : HOST_W'($urandom);
    case ($urandom_range(19))
      0:       p.flow = '0;
      1:       p.flow = '1;
      default: p.flow = $urandom;
    endcase
    return p;
  endfunction

  task automatic enqueue(pkt_t p);
    pkt_q.insert(pkt_q.size(), p);
    n_queued++;
  endtask

  task automatic queue_pkt(logic [MODE_W-1:0] mode, logic [HOST_W-1:0] src,
                           logic [HOST_W-1:0] dst, logic [FLOW_W-1:0] flow);
    pkt_t p;
    p.mode = mode;
    p.src  = src;
    p.dst  = dst;
    p.flow = flow;
    enqueue(p);
  endtask

  // every queued request has been sent and its result checked
  task automatic wait_idle();
    do @(posedge clk);
    while (n_checked != n_queued);
  endtask

  task automatic write_balance(logic [BAL_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    bal_mode     = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // driver: one request held until accepted, prediction taken at acceptance
  always @(posedge clk) begin
    pkt_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        hop_q.insert(hop_q.size(),
                     predict_hop(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[47:16]));
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pkt_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pkt_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {nxt.flow, nxt.dst, nxt.src};
          in_tuser  <= nxt.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hop_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (hop_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_tdata, 0);
        end else begin
          want = hop_q.pop_front();
          if (out_tuser !== want.arrived) report_mismatch("arrived", out_tuser, want.arrived);
          if (out_tdata[PORT_W-1:0] !== want.port)
            report_mismatch("out_port", out_tdata[PORT_W-1:0], want.port);
          if (out_tdata[OUT_TDATA_W-1:PORT_W] !== '0)
            report_mismatch("tdata pad", out_tdata[OUT_TDATA_W-1:PORT_W], 0);
          n_checked++;
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int bal_seq[8]  = '{1, 0, 2, 3, 0, 1, 0, 3};
    int idle_seq[8] = '{0, 1, 2, 3, 0, 3, 2, 1};
    for (int i = 0; i < HOST_COUNT; i++) spray_cnt[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset balance mode is spraying
    queue_pkt(lsnhs_pkg::MODE_HOST_IN, 8'h00, 8'h00, 32'h0);
    queue_pkt(lsnhs_pkg::MODE_HOST_IN, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'h00, 8'h0F, 32'h0);
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'h3F, 8'h30, 32'h0);
    repeat (5) queue_pkt(lsnhs_pkg::MODE_UPLINK, 8'h00, 8'hFF, 32'h0);  // counter wraps
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'hFF, 8'h00, 32'h0);
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'h10, 8'h00, 32'h0);
    queue_pkt(lsnhs_pkg::MODE_AGG,     8'h00, 8'h00, 32'h0);
    queue_pkt(lsnhs_pkg::MODE_AGG,     8'h00, 8'hFF, 32'h0);
    queue_pkt(lsnhs_pkg::MODE_CORE,    8'h00, 8'hFF, 32'h0);
    queue_pkt(lsnhs_pkg::MODE_CORE,    8'h00, 8'h10, 32'h0);
    write_balance(lsnhs_pkg::BAL_ECMP);
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'hFF, 8'h00, 32'hFFFF_FFFF);    // sum wraps
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'h01, 8'hF2, 32'h1);
    queue_pkt(lsnhs_pkg::MODE_HOST_IN, 8'h12, 8'h34, 32'h5);
    write_balance(BAL_FIXED_LO);
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'h00, 8'hFF, 32'h3);
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'h20, 8'h21, 32'h0);
    write_balance(BAL_FIXED_HI);
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'h00, 8'hFF, 32'h2);
    queue_pkt(lsnhs_pkg::MODE_AGG,     8'h00, 8'h80, 32'h0);
    // counter of host 0 must have survived the other modes
    write_balance(lsnhs_pkg::BAL_SPRAY);
    queue_pkt(lsnhs_pkg::MODE_UPLINK,  8'h00, 8'hFF, 32'h0);

    for (int ph = 0; ph < 8; ph++) begin
      write_balance(BAL_W'(bal_seq[ph]));
      case (idle_seq[ph])
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 57; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      repeat (PHASE_ITEMS) enqueue(rand_pkt());
    end

    wait_idle();
    repeat (16) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d mismatches", n_sent, n_checked,
             n_errors);
    $display("covered all link kinds, balance modes 0 to 3 and four idle profiles");
    if (n_errors == 0) begin
      $display("tb_leaf_spine_next_hop_select: PASS");
    end else begin
      $display("tb_leaf_spine_next_hop_select: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", hop_q.size());
    $display("tb_leaf_spine_next_hop_select: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lsnhs_pkg.sv
rtl/lsnhs_spray_mem.sv
rtl/lsnhs_hash.sv
rtl/lsnhs_route.sv
rtl/leaf_spine_next_hop_select.sv
tb/sv/tb_leaf_spine_next_hop_select.sv
